[rtl/fpa_pkg.sv]
// Package for the fixed-point ALU: opcodes and default parameter values.
`timescale 1ns / 1ps
package fpa_pkg;
  localparam int FracBitsDefault  = 8;
  localparam int DataWidthDefault = 32;
  localparam int PortWidth        = 32;

  localparam logic [3:0] OP_ADD      = 4'd0;
  localparam logic [3:0] OP_SUB      = 4'd1;
  localparam logic [3:0] OP_MUL      = 4'd2;
  localparam logic [3:0] OP_DIV      = 4'd3;
  localparam logic [3:0] OP_MIN      = 4'd4;
  localparam logic [3:0] OP_MAX      = 4'd5;
  localparam logic [3:0] OP_INC      = 4'd6;
  localparam logic [3:0] OP_DEC      = 4'd7;
  localparam logic [3:0] OP_FROM_INT = 4'd8;
  localparam logic [3:0] OP_TO_INT   = 4'd9;
endpackage

[rtl/fpa_divider.sv]
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
`timescale 1ns / 1ps
module fpa_divider import fpa_pkg::*; #(
  parameter int QW = 62,
  parameter int DW = 32,
  parameter int TW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_valid,
  input  logic [QW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  input  logic [TW-1:0] tag_in,
  output logic          out_valid,
  output logic [QW-1:0] quotient,
  output logic [TW-1:0] tag_out
);
  // Each stage holds the partial remainder, the dividend bits still to shift in,
  // and the quotient bits found so far.
  logic [QW:0]   vld;
  logic [DW:0]   rem [QW+1];
  logic [QW-1:0] num [QW+1];
  logic [DW-1:0] den [QW+1];
  logic [TW-1:0] tag [QW+1];

  always_comb begin
    vld[0] = in_valid;
    rem[0] = '0;
    num[0] = dividend;
    den[0] = divisor;
    tag[0] = tag_in;
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [DW:0] trial;
    logic [DW+1:0] diff;
    always_comb begin
      trial = {rem[s][DW-1:0], num[s][QW-1]};
      diff  = {1'b0, trial} - {2'b00, den[s]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (adv) begin
        vld[s+1] <= vld[s];
      end
      if (adv) begin
        rem[s+1] <= diff[DW+1] ? trial : diff[DW:0];
        num[s+1] <= {num[s][QW-2:0], ~diff[DW+1]};
        den[s+1] <= den[s];
        tag[s+1] <= tag[s];
      end
    end
  end

  assign out_valid = vld[QW];
  assign quotient  = num[QW];
  assign tag_out   = tag[QW];
endmodule

[rtl/fixed_point_alu.sv]
// Top level of the pipelined signed fixed-point ALU.
`timescale 1ns / 1ps
//  channel | valid     | stall     | payload
//  input   | in_valid  | in_stall  | opcode, operand_a, operand_b
//  output  | out_valid | out_stall | result, less, equal, greater, overflow,
//          |           |           | divide_by_zero
//
// One item may enter in every cycle while in_stall is low. Every item,
// whatever its opcode, goes through the same pipeline: one decode stage, a
// one-stage multiplier, then the divider with one stage per quotient bit
// (DATA_WIDTH + FRAC_BITS stages), then a result stage. The whole pipeline
// moves as one when the output stage is empty or taken; a stall at the
// output holds every stage, so nothing is lost or repeated. Reset clears
// only the valid bits.
module fixed_point_alu import fpa_pkg::*; #(
  parameter int FRAC_BITS  = FracBitsDefault,
  parameter int DATA_WIDTH = DataWidthDefault
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [3:0]                  opcode,
  input  logic signed [PortWidth-1:0] operand_a,
  input  logic signed [PortWidth-1:0] operand_b,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [PortWidth-1:0] result,
  output logic                        less,
  output logic                        equal,
  output logic                        greater,
  output logic                        overflow,
  output logic                        divide_by_zero
);
  localparam int DW = DATA_WIDTH;
  localparam int QW = DATA_WIDTH + FRAC_BITS;   // dividend magnitude width
  localparam int PW = 2 * DATA_WIDTH;           // full product width

  // Control and side values that travel beside the divider.
  typedef struct packed {
    logic [3:0]        op;
    logic              lt;
    logic              eq;
    logic              gt;
    logic              dz;
    logic              qneg;
    logic [PW+1:0]     v;     // exact result of every operation but divide
  } side_t;

  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Stage 1: sign-extend, compare, and the cheap operations.
  logic signed [DW-1:0] a, b;
  assign a = operand_a[DW-1:0];
  assign b = operand_b[DW-1:0];

  logic                 s1_valid;
  side_t                s1_side;
  logic signed [DW-1:0] s1_a, s1_b;
  logic [QW-1:0]        s1_num;
  logic [DW-1:0]        s1_den;
  side_t                side_next;
  logic signed [PW+1:0] ax, bx;

  always_comb begin
    ax = (PW+2)'(a);
    bx = (PW+2)'(b);
    side_next.op   = opcode;
    side_next.lt   = a < b;
    side_next.eq   = a == b;
    side_next.gt   = a > b;
    side_next.dz   = (opcode == OP_DIV) && (b == '0);
    side_next.qneg = a[DW-1] ^ b[DW-1];
    case (opcode)
      OP_ADD:      side_next.v = ax + bx;
      OP_SUB:      side_next.v = ax - bx;
      OP_MIN:      side_next.v = (a < b) ? ax : bx;
      OP_MAX:      side_next.v = (a > b) ? ax : bx;
      OP_INC:      side_next.v = ax + 1;
      OP_DEC:      side_next.v = ax - 1;
      OP_FROM_INT: side_next.v = ax <<< FRAC_BITS;
      // Truncate toward zero: bias a negative value before the shift.
      OP_TO_INT:   side_next.v = (a[DW-1] ? ax + ((PW+2)'(1) <<< FRAC_BITS) - 1 : ax)
                                 >>> FRAC_BITS;
      default:     side_next.v = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
    if (adv) begin
      s1_side <= side_next;
      s1_a    <= a;
      s1_b    <= b;
      s1_num  <= QW'(a[DW-1] ? -ax : ax) << FRAC_BITS;
      s1_den  <= b[DW-1] ? DW'(-bx) : DW'(bx);
    end
  end

  // Stage 2: the product, registered, then the floor shift in stage 3.
  logic                 s2_valid;
  side_t                s2_side;
  logic signed [PW-1:0] s2_prod;
  logic [QW-1:0]        s2_num;
  logic [DW-1:0]        s2_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
    if (adv) begin
      s2_side <= s1_side;
      s2_prod <= s1_a * s1_b;
      s2_num  <= s1_num;
      s2_den  <= s1_den;
    end
  end

  side_t s2_fold;
  always_comb begin
    s2_fold = s2_side;
    if (s2_side.op == OP_MUL) begin
      s2_fold.v = (PW+2)'(s2_prod >>> FRAC_BITS);
    end
  end

  // Divider stages; a zero divisor gives all-ones which is replaced later.
  logic              d_valid;
  logic [QW-1:0]     d_quot;
  side_t             d_side;

  fpa_divider #(.QW(QW), .DW(DW), .TW($bits(side_t))) u_div (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(s2_valid), .dividend(s2_num), .divisor(s2_den),
    .tag_in(s2_fold), .out_valid(d_valid), .quotient(d_quot), .tag_out(d_side)
  );

  // Final stage: pick the value, wrap it and flag overflow.
  logic signed [PW+1:0] fin;
  logic signed [DW-1:0] lo_wrap;
  always_comb begin
    if (d_side.op == OP_DIV) begin
      if (d_side.dz) fin = '0;
      else fin = d_side.qneg ? -(PW+2)'(d_quot) : (PW+2)'(d_quot);
    end else begin
      fin = d_side.v;
    end
    lo_wrap = fin[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= d_valid;
    end
    if (adv) begin
      result         <= PortWidth'(lo_wrap);
      less           <= d_side.lt;
      equal          <= d_side.eq;
      greater        <= d_side.gt;
      overflow       <= (PW+2)'(lo_wrap) != fin;
      divide_by_zero <= d_side.dz;
    end
  end
endmodule

[rtl/fpa_checker.sv]
// Port-level checker for the fixed-point ALU, bound to the top level.
`timescale 1ns / 1ps
module fpa_checker import fpa_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] result,
  input logic        less,
  input logic        equal,
  input logic        greater,
  input logic        overflow,
  input logic        divide_by_zero
);
  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot({less, equal, greater}))
    else $error("compare flags not one-hot");
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_by_zero |-> result == '0 && !overflow)
    else $error("divide by zero result wrong");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result))
    else $error("stalled item changed");
  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");
endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .result(result), .less(less),
  .equal(equal), .greater(greater), .overflow(overflow),
  .divide_by_zero(divide_by_zero)
);
